// ===== design/cmf_pkg.sv =====
// Shared types, codes and constants of the cross morphology filter.
`default_nettype none
package cmf_pkg;

    // Sizes fixed by the stream format
    localparam int PIX_W       = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_TARGET     = 2'd1,
        CFG_SUBSTITUTE = 2'd2,
        CFG_WIDTH      = 2'd3
    } t_cfg_idx;

    // Filter modes; the unused code passes pixels through
    typedef enum logic [MODE_W-1:0] {
        MODE_REPLACE  = 2'd0,
        MODE_DILATION = 2'd1,
        MODE_EROSION  = 2'd2
    } t_mode;

    // Input opcodes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    // Filter settings seen by the compare network
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [PIX_W-1:0]  target;
        logic [PIX_W-1:0]  subst;
    } t_cfg;

    // Which neighbours lie inside the image
    typedef struct packed {
        logic up;
        logic lf;
        logic rt;
        logic dn;
    } t_nb_ok;

    // One result beat
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eor;
        logic             eof;
    } t_result;

endpackage
`default_nettype wire

// ===== design/cmf_line_buf.sv =====
// Upper and middle line buffers with registered reads and upper-line forwarding.
`default_nettype none
module cmf_line_buf #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  wire logic                     i_clk,
    // read side, one column and its right neighbour
    input  wire logic                     i_rd_en,
    input  wire logic [AW-1:0]            i_rd_addr_c,
    input  wire logic [AW-1:0]            i_rd_addr_r,
    output logic      [cmf_pkg::PIX_W-1:0] o_mid_c,
    output logic      [cmf_pkg::PIX_W-1:0] o_mid_r,
    output logic      [cmf_pkg::PIX_W-1:0] o_upper,
    // middle line write
    input  wire logic                     i_mid_we,
    input  wire logic [AW-1:0]            i_mid_waddr,
    input  wire logic [cmf_pkg::PIX_W-1:0] i_mid_wdata,
    // upper line write
    input  wire logic                     i_up_we,
    input  wire logic [AW-1:0]            i_up_waddr,
    input  wire logic [cmf_pkg::PIX_W-1:0] i_up_wdata
);

    logic [cmf_pkg::PIX_W-1:0] r_mid_mem [MAX_WIDTH];
    logic [cmf_pkg::PIX_W-1:0] r_up_mem  [MAX_WIDTH];
    logic [cmf_pkg::PIX_W-1:0] r_up_rd;
    logic [cmf_pkg::PIX_W-1:0] r_fwd_data;
    logic                      r_fwd_hit;

    // middle line: two read ports, read-before-write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_mid_c <= r_mid_mem[i_rd_addr_c];
            o_mid_r <= r_mid_mem[i_rd_addr_r];
        end
        if (i_mid_we) begin
            r_mid_mem[i_mid_waddr] <= i_mid_wdata;
        end
    end

    // upper line: a write landing on the entry read in the same cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_rd    <= r_up_mem[i_rd_addr_c];
            r_fwd_hit  <= i_up_we && (i_up_waddr == i_rd_addr_c);
            r_fwd_data <= i_up_wdata;
        end
        if (i_up_we) begin
            r_up_mem[i_up_waddr] <= i_up_wdata;
        end
    end

    assign o_upper = r_fwd_hit ? r_fwd_data : r_up_rd;

endmodule
`default_nettype wire

// ===== design/cmf_filter.sv =====
// Cross window compare network: replace, dilation and erosion rules.
`default_nettype none
module cmf_filter (
    input  wire cmf_pkg::t_cfg              i_cfg,
    input  wire cmf_pkg::t_nb_ok            i_ok,
    input  wire logic [cmf_pkg::PIX_W-1:0]  i_center,
    input  wire logic [cmf_pkg::PIX_W-1:0]  i_up,
    input  wire logic [cmf_pkg::PIX_W-1:0]  i_lf,
    input  wire logic [cmf_pkg::PIX_W-1:0]  i_rt,
    input  wire logic [cmf_pkg::PIX_W-1:0]  i_dn,
    output logic      [cmf_pkg::PIX_W-1:0]  o_pixel
);

    logic ctr_hit;
    logic any_hit;
    logic any_miss;

    // neighbour tests, out-of-image neighbours left out
    always_comb begin
        ctr_hit  = (i_center == i_cfg.target);
        any_hit  = (i_ok.up && (i_up == i_cfg.target)) ||
                   (i_ok.lf && (i_lf == i_cfg.target)) ||
                   (i_ok.rt && (i_rt == i_cfg.target)) ||
                   (i_ok.dn && (i_dn == i_cfg.target));
        any_miss = (i_ok.up && (i_up != i_cfg.target)) ||
                   (i_ok.lf && (i_lf != i_cfg.target)) ||
                   (i_ok.rt && (i_rt != i_cfg.target)) ||
                   (i_ok.dn && (i_dn != i_cfg.target));
    end

    // mode select
    always_comb begin
        case (i_cfg.mode)
            cmf_pkg::MODE_REPLACE: begin
                o_pixel = ctr_hit ? i_cfg.subst : i_center;
            end
            cmf_pkg::MODE_DILATION: begin
                o_pixel = (!ctr_hit && any_hit) ? i_cfg.target : i_center;
            end
            cmf_pkg::MODE_EROSION: begin
                o_pixel = (ctr_hit && any_miss) ? i_cfg.subst : i_center;
            end
            default: begin
                o_pixel = i_center;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/cmf_out_fifo.sv =====
// Two-entry result queue that parts the filter from the output handshake.
`default_nettype none
module cmf_out_fifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cmf_pkg::t_result  i_data,
    input  wire logic              i_pop,
    output cmf_pkg::t_result       o_data,
    output logic                   o_valid,
    output logic [1:0]             o_count
);

    cmf_pkg::t_result r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_count;
    logic [1:0]       n_count;

    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(i_pop);
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_valid = (r_count != 2'd0);
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== design/cross_morphology_filter_top.sv =====
// Top level of the cross morphology filter: window control, line buffers, result queue.
`default_nettype none
// Takes one pixel or flush beat per clock while o_stall is low; a result is
// registered in the read stage, then in the result queue. The upper and middle
// lines live in two MAX_WIDTH-deep RAMs with registered reads; the middle line is
// read at the center and right-hand columns in the same cycle, and a write to
// the upper line is forwarded to a read of the same entry in the same cycle.
// A two-beat result queue lets the input keep flowing while a result waits.
// Line contents are undefined after reset; no clearing pass is run, and the
// first image row fills the middle line before any result appears. Each image
// row is emitted one row late; after the last pixel, one flush beat per column
// drains the final row, the last one marked end_of_frame. Configuration writes
// are always accepted and must be made while no item is in flight.
module cross_morphology_filter_top #(
    parameter int MAX_WIDTH = cmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_opcode,
    input  wire logic [cmf_pkg::PIX_W-1:0]       i_in_pixel,
    // output stream
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cmf_pkg::PIX_W-1:0]       o_out_pixel,
    output logic                                 o_end_of_row,
    output logic                                 o_end_of_frame,
    // configuration writes
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [cmf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [cmf_pkg::WIDTH_REG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > cmf_pkg::WIDTH_REG_W) ? WW : cmf_pkg::WIDTH_REG_W;

    // configuration registers
    logic [cmf_pkg::MODE_W-1:0]      r_mode;
    logic [cmf_pkg::PIX_W-1:0]       r_target;
    logic [cmf_pkg::PIX_W-1:0]       r_subst;
    logic [cmf_pkg::WIDTH_REG_W-1:0] r_image_width;

    // frame position
    logic [AW-1:0] r_col;
    logic [AW-1:0] n_col;
    logic [1:0]    r_rows;
    logic [1:0]    n_rows;
    logic [AW-1:0] r_flush;
    logic [AW-1:0] n_flush;

    // item in the read stage
    logic                      r_s1_valid;
    logic                      r_s1_upwe;
    logic [AW-1:0]             r_s1_addr;
    logic [cmf_pkg::PIX_W-1:0] r_s1_dn;
    cmf_pkg::t_nb_ok           r_s1_ok;
    logic                      r_s1_eor;
    logic                      r_s1_eof;
    logic [cmf_pkg::PIX_W-1:0] r_prev_center;

    // decode of the incoming beat
    logic                      acc;
    logic                      n_s1_valid;
    logic                      n_s1_upwe;
    logic [AW-1:0]             n_s1_addr;
    cmf_pkg::t_nb_ok           n_s1_ok;
    logic                      n_s1_eor;
    logic                      n_s1_eof;
    logic [AW-1:0]             rd_addr_r;
    logic                      mid_we;
    logic [CW-1:0]             img_ext;
    logic [CW-1:0]             eff_w;
    logic [AW-1:0]             pos;
    logic                      pos_last;
    logic [1:0]                rows_eff;

    // line buffer and filter signals
    logic [cmf_pkg::PIX_W-1:0] mid_c;
    logic [cmf_pkg::PIX_W-1:0] mid_r;
    logic [cmf_pkg::PIX_W-1:0] upper;
    logic [cmf_pkg::PIX_W-1:0] filt_pixel;
    cmf_pkg::t_cfg             cfg;
    cmf_pkg::t_result          s1_res;
    cmf_pkg::t_result          head;
    logic                      pop;
    logic [1:0]                fifo_count;
    logic [2:0]                fill_ahead;

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= cmf_pkg::MODE_REPLACE;
            r_target      <= '0;
            r_subst       <= '0;
            r_image_width <= cmf_pkg::WIDTH_REG_W'(cmf_pkg::MAX_WIDTH_DEF);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cmf_pkg::CFG_MODE:       r_mode        <= i_cfg_data[cmf_pkg::MODE_W-1:0];
                cmf_pkg::CFG_TARGET:     r_target      <= i_cfg_data[cmf_pkg::PIX_W-1:0];
                cmf_pkg::CFG_SUBSTITUTE: r_subst       <= i_cfg_data[cmf_pkg::PIX_W-1:0];
                cmf_pkg::CFG_WIDTH:      r_image_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective width, clamped to 1..MAX_WIDTH
    always_comb begin
        img_ext = CW'(r_image_width);
        if (img_ext == '0) begin
            eff_w = CW'(1);
        end else if (img_ext > CW'(MAX_WIDTH)) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = img_ext;
        end
    end

    // input handshake: room for this beat once the queue has taken the one in flight
    assign pop        = o_valid && !i_stall;
    assign fill_ahead = 3'(fifo_count) + 3'(r_s1_valid) - 3'(pop);
    assign o_stall    = (fill_ahead > 3'd1);
    assign acc        = i_valid && !o_stall;

    // beat decode and position update
    always_comb begin
        n_col      = r_col;
        n_rows     = r_rows;
        n_flush    = r_flush;
        n_s1_valid = 1'b0;
        n_s1_upwe  = 1'b0;
        n_s1_eor   = 1'b0;
        n_s1_eof   = 1'b0;
        n_s1_ok    = '0;
        mid_we     = 1'b0;
        rows_eff   = r_rows;
        pos        = r_flush;
        if (i_opcode == cmf_pkg::OP_PIXEL) begin
            // a pixel during a drain starts a new frame
            rows_eff = (r_flush != '0) ? 2'd0 : r_rows;
            pos      = (r_flush != '0) ? '0 : r_col;
        end
        pos_last  = ((CW+1)'(pos) + (CW+1)'(1)) >= (CW+1)'(eff_w);
        n_s1_addr = pos;
        rd_addr_r = AW'(pos + AW'(1));

        if (acc) begin
            if (i_opcode == cmf_pkg::OP_PIXEL) begin
                mid_we     = 1'b1;
                n_s1_valid = (rows_eff != 2'd0);
                n_s1_upwe  = (rows_eff != 2'd0);
                n_s1_eor   = pos_last;
                n_s1_ok    = '{up: (rows_eff == 2'd2), lf: (pos != '0),
                               rt: !pos_last, dn: 1'b1};
                n_flush    = '0;
                if (pos_last) begin
                    n_col  = '0;
                    n_rows = (rows_eff == 2'd2) ? 2'd2 : rows_eff + 2'd1;
                end else begin
                    n_col  = pos + AW'(1);
                    n_rows = rows_eff;
                end
            end else if ((r_rows != 2'd0) && (r_col == '0)) begin
                n_s1_valid = 1'b1;
                n_s1_eor   = pos_last;
                n_s1_eof   = pos_last;
                n_s1_ok    = '{up: (r_rows == 2'd2), lf: (pos != '0),
                               rt: !pos_last, dn: 1'b0};
                if (pos_last) begin
                    n_flush = '0;
                    n_col   = '0;
                    n_rows  = 2'd0;
                end else begin
                    n_flush = pos + AW'(1);
                end
            end
        end
    end

    // position and read-stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_rows     <= 2'd0;
            r_flush    <= '0;
            r_s1_valid <= 1'b0;
            r_s1_upwe  <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_rows     <= n_rows;
            r_flush    <= n_flush;
            r_s1_valid <= n_s1_valid;
            r_s1_upwe  <= n_s1_upwe;
        end
    end

    // read-stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr <= n_s1_addr;
            r_s1_dn   <= i_in_pixel;
            r_s1_ok   <= n_s1_ok;
            r_s1_eor  <= n_s1_eor;
            r_s1_eof  <= n_s1_eof;
        end
        // left neighbour is the center of the previous result
        if (r_s1_valid) begin
            r_prev_center <= mid_c;
        end
    end

    cmf_line_buf #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_rd_en     (acc),
        .i_rd_addr_c (pos),
        .i_rd_addr_r (rd_addr_r),
        .o_mid_c     (mid_c),
        .o_mid_r     (mid_r),
        .o_upper     (upper),
        .i_mid_we    (mid_we),
        .i_mid_waddr (pos),
        .i_mid_wdata (i_in_pixel),
        .i_up_we     (r_s1_valid && r_s1_upwe),
        .i_up_waddr  (r_s1_addr),
        .i_up_wdata  (mid_c)
    );

    assign cfg = '{mode: r_mode, target: r_target, subst: r_subst};

    cmf_filter u_filter (
        .i_cfg    (cfg),
        .i_ok     (r_s1_ok),
        .i_center (mid_c),
        .i_up     (upper),
        .i_lf     (r_prev_center),
        .i_rt     (mid_r),
        .i_dn     (r_s1_dn),
        .o_pixel  (filt_pixel)
    );

    assign s1_res = '{pixel: filt_pixel, eor: r_s1_eor, eof: r_s1_eof};

    cmf_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_res),
        .i_pop   (pop),
        .o_data  (head),
        .o_valid (o_valid),
        .o_count (fifo_count)
    );

    assign o_out_pixel    = head.pixel;
    assign o_end_of_row   = head.eor;
    assign o_end_of_frame = head.eof;

endmodule
`default_nettype wire
